>>> design/nplab_pkg.sv
// Package for the nearest palette labeler: sizes, codes, the transaction
// record that travels along the cell chain, and the squared-difference helper.
// No dependencies.
package nplab_pkg;

  localparam int unsigned PaletteEntries = 10;
  localparam int unsigned IdxW  = 4;
  localparam int unsigned CntW  = IdxW + 1;
  localparam int unsigned ChanW = 8;
  localparam int unsigned DistW = 18;
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 4;

  // Larger than any real two-channel distance, so entry 0 always takes over.
  localparam logic [DistW-1:0] DistStart = DistW'(255 * 255 * 3);

  typedef enum logic {
    OpClassify = 1'b0,
    OpWrite    = 1'b1
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgActiveColors = 4'd0,
    CfgReplaceColor = 4'd1
  } cfg_reg_e;

  typedef struct packed {
    op_e              op;
    logic [IdxW-1:0]  idx;
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic [DistW-1:0] best_dist;
    logic [IdxW-1:0]  best_idx;
    logic [ChanW-1:0] best_red;
    logic [ChanW-1:0] best_green;
    logic [ChanW-1:0] best_blue;
  } item_t;

  function automatic logic [2*ChanW-1:0] sq_diff(input logic [ChanW-1:0] a,
                                                 input logic [ChanW-1:0] b);
    logic [ChanW-1:0] diff;
    diff = (a > b) ? (a - b) : (b - a);
    return diff * diff;
  endfunction

endpackage

>>> design/nplab_cell.sv
// One cell of the palette chain: holds a single palette entry, compares the
// passing pixel against it and forwards the running best to its neighbour.
// Depends on nplab_pkg.
module nplab_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic [nplab_pkg::IdxW-1:0]    cell_idx_i,
  input  logic [nplab_pkg::CntW-1:0]    count_i,
  input  logic                          valid_i,
  input  nplab_pkg::item_t              item_i,
  output logic                          valid_o,
  output nplab_pkg::item_t              item_o
);

  logic [3*nplab_pkg::ChanW-1:0]  pal_q;
  logic [nplab_pkg::ChanW-1:0]    pal_red, pal_green, pal_blue;
  logic [nplab_pkg::DistW-1:0]    cand_dist;
  logic                           take;
  logic                           valid_q;
  nplab_pkg::item_t               item_d, item_q;

  assign {pal_red, pal_green, pal_blue} = pal_q;

  always_comb begin
    cand_dist = nplab_pkg::DistW'(nplab_pkg::sq_diff(item_i.green, pal_green))
              + nplab_pkg::DistW'(nplab_pkg::sq_diff(item_i.blue, pal_blue));
    // only entries inside the active count take part; ties keep the earlier one
    take = (item_i.op == nplab_pkg::OpClassify)
        && ({1'b0, cell_idx_i} < count_i)
        && (cand_dist < item_i.best_dist);
    item_d = item_i;
    if (take) begin
      item_d.best_dist  = cand_dist;
      item_d.best_idx   = cell_idx_i;
      item_d.best_red   = pal_red;
      item_d.best_green = pal_green;
      item_d.best_blue  = pal_blue;
    end
  end

  // palette entry: undefined until written
  always_ff @(posedge clk_i) begin
    if (en_i && valid_i && (item_i.op == nplab_pkg::OpWrite)
        && (item_i.idx == cell_idx_i)) begin
      pal_q <= {item_i.red, item_i.green, item_i.blue};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

>>> design/nearest_palette_labeler.sv
// Nearest palette labeler: a chain of PALETTE_ENTRIES cells, one palette entry
// in each, followed by an output register. Every transaction, pixel or palette
// write, walks the chain one cell per clock while the chain advances, and a
// pixel result is then registered at the output; a new transaction can be
// accepted every clock in which the chain advances. The whole chain advances
// together: while a result sits unaccepted at the output, the chain and the
// input are held. Palette writes give no result and land in their cell as they
// pass it. Write configuration only once the chain is empty: PALETTE_ENTRIES
// unstalled cycles after the last transaction, with its result taken.
// Depends on nplab_pkg and nplab_cell.
module nearest_palette_labeler (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [nplab_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [nplab_pkg::CfgDataW-1:0]    cfg_data_i,
  // input items
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              operation_i,
  input  logic [nplab_pkg::IdxW-1:0]        entry_index_i,
  input  logic [nplab_pkg::ChanW-1:0]       red_i,
  input  logic [nplab_pkg::ChanW-1:0]       green_i,
  input  logic [nplab_pkg::ChanW-1:0]       blue_i,
  // results
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [nplab_pkg::IdxW-1:0]        label_o,
  output logic [nplab_pkg::ChanW-1:0]       out_red_o,
  output logic [nplab_pkg::ChanW-1:0]       out_green_o,
  output logic [nplab_pkg::ChanW-1:0]       out_blue_o
);

  localparam int unsigned Pe = nplab_pkg::PaletteEntries;

  logic [nplab_pkg::IdxW-1:0]   active_colors_q;
  logic                         replace_color_q;
  logic [nplab_pkg::CntW-1:0]   act_ext, count;
  logic                         advance;
  logic                         chain_valid [Pe+1];
  nplab_pkg::item_t             chain_item  [Pe+1];
  logic                         out_valid_q, out_valid_d;
  logic [nplab_pkg::IdxW-1:0]   label_q;
  logic [nplab_pkg::ChanW-1:0]  red_q, green_q, blue_q;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_colors_q <= nplab_pkg::IdxW'(10);
      replace_color_q <= 1'b1;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == nplab_pkg::CfgActiveColors) begin
        active_colors_q <= cfg_data_i[nplab_pkg::IdxW-1:0];
      end else if (cfg_index_i == nplab_pkg::CfgReplaceColor) begin
        replace_color_q <= cfg_data_i[0];
      end
    end
  end

  // zero counts as one, anything above the palette size saturates
  always_comb begin
    act_ext = {1'b0, active_colors_q};
    if (act_ext > nplab_pkg::CntW'(Pe)) begin
      count = nplab_pkg::CntW'(Pe);
    end else if (act_ext == '0) begin
      count = nplab_pkg::CntW'(1);
    end else begin
      count = act_ext;
    end
  end

  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = advance;

  always_comb begin
    chain_valid[0]           = in_valid_i;
    chain_item[0].op         = nplab_pkg::op_e'(operation_i);
    chain_item[0].idx        = entry_index_i;
    chain_item[0].red        = red_i;
    chain_item[0].green      = green_i;
    chain_item[0].blue       = blue_i;
    chain_item[0].best_dist  = nplab_pkg::DistStart;
    chain_item[0].best_idx   = '0;
    chain_item[0].best_red   = '0;
    chain_item[0].best_green = '0;
    chain_item[0].best_blue  = '0;
  end

  for (genvar k = 0; k < Pe; k++) begin : g_cell
    nplab_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .en_i       (advance),
      .cell_idx_i (nplab_pkg::IdxW'(k)),
      .count_i    (count),
      .valid_i    (chain_valid[k]),
      .item_i     (chain_item[k]),
      .valid_o    (chain_valid[k+1]),
      .item_o     (chain_item[k+1])
    );
  end

  // output register: only classify transactions leave a result
  assign out_valid_d = chain_valid[Pe] && (chain_item[Pe].op == nplab_pkg::OpClassify);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      label_q <= chain_item[Pe].best_idx;
      if (replace_color_q) begin
        red_q   <= chain_item[Pe].best_red;
        green_q <= chain_item[Pe].best_green;
        blue_q  <= chain_item[Pe].best_blue;
      end else begin
        red_q   <= chain_item[Pe].red;
        green_q <= chain_item[Pe].green;
        blue_q  <= chain_item[Pe].blue;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign label_o     = label_q;
  assign out_red_o   = red_q;
  assign out_green_o = green_q;
  assign out_blue_o  = blue_q;

  // label always lies inside the active part of the palette
  a_label_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ({1'b0, label_q} < count))
    else $error("label outside active palette");

  // a palette write leaving the chain never produces a result
  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && chain_valid[Pe] && (chain_item[Pe].op == nplab_pkg::OpWrite))
    |=> !out_valid_q)
    else $error("palette write produced a result");

  // a held output freezes the end of the chain
  a_chain_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(chain_valid[Pe]))
    else $error("chain moved while output stalled");

  // a pixel leaving the chain always carries a distance below the start value
  a_best_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_d |-> (chain_item[Pe].best_dist < nplab_pkg::DistStart))
    else $error("pixel left chain without a match");

endmodule
